>>> rtl/core/chained_hash_set_macros.svh
// Assertion macros for the chained hash set.
`ifndef CHAINED_HASH_SET_MACROS_SVH
`define CHAINED_HASH_SET_MACROS_SVH
`ifndef SYNTH
`define CHS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("chained_hash_set: assertion failed");
`define CHS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("chained_hash_set: assertion failed");
`else
`define CHS_ASSERT(lbl, prop)
`define CHS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> rtl/core/chs_pkg.sv
// Types and constants of the chained hash set.
`default_nettype none
package chs_pkg;
  localparam int MAX_BUCKETS_DEF = 64;
  localparam int NODE_POOL_DEF   = 256;
  localparam int KEY_W           = 32;
  localparam int FUNC_W          = 2;
  localparam int STATUS_W        = 3;
  localparam int LEN_W           = 9;
  localparam int CFG_W           = 7;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;
  localparam int MOD_DIG         = 4;
  localparam int MOD_CYC         = 16;
  localparam int MOD_CNT_W       = 4;
  localparam int SCAN_G          = 8;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_STATS  = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_INSERTED = 3'd0,
    STAT_DUP      = 3'd1,
    STAT_REMOVED  = 3'd2,
    STAT_NOTFOUND = 3'd3,
    STAT_FULL     = 3'd4,
    STAT_STATS    = 3'd5,
    STAT_CLEARED  = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MOD,
    S_HRD,
    S_HGET,
    S_NRD,
    S_NCHK,
    S_SCAN,
    S_INS,
    S_SHRD,
    S_SHGET,
    S_SWALK,
    S_SNXT,
    S_CLEAR,
    S_DONE
  } state_e;
endpackage
`default_nettype wire

>>> rtl/core/chained_hash_set.sv
// Chained hash set: top level with sequencer, modulo unit, chain walker and node pool.
// One command at a time; in_stall_o is high while a command is in progress. Insert and
// remove pass through the shared modulo unit (4 dividend bits per cycle), the bucket
// head read (S_HRD, S_HGET) and, per chain node visited, a registered node memory read
// (S_NRD, S_NCHK); S_NRD also sees the end of the chain when the key is not in it. An
// insert of a new key adds a free-node scan (8 pool bits per cycle) and the write state
// S_INS. Stats reads the head and walks the chain of every configured bucket. S_DONE
// moves the result into the output register once it is free; that register holds it
// while the next command is accepted. There is no clearing pass after reset.
`default_nettype none
`include "chained_hash_set_macros.svh"
module chained_hash_set #(
  parameter int MAX_BUCKETS = chs_pkg::MAX_BUCKETS_DEF,
  parameter int NODE_POOL   = chs_pkg::NODE_POOL_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [chs_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [chs_pkg::FUNC_W-1:0]  func_i,
  input  wire logic [chs_pkg::KEY_W-1:0]   key_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [chs_pkg::STATUS_W-1:0]     status_o,
  output logic [chs_pkg::LEN_W-1:0]        min_len_o,
  output logic [chs_pkg::LEN_W-1:0]        max_len_o
);
  localparam int NW   = $clog2(NODE_POOL + 1);
  localparam int IW   = (NODE_POOL > 1) ? $clog2(NODE_POOL) : 1;
  localparam int BW   = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int DW   = $clog2(MAX_BUCKETS + 1);
  localparam int LW   = (NW > chs_pkg::LEN_W) ? NW : chs_pkg::LEN_W;
  localparam int NG   = (NODE_POOL + chs_pkg::SCAN_G - 1) / chs_pkg::SCAN_G;
  localparam int GW   = (NG > 1) ? $clog2(NG) : 1;
  localparam int PADW = NG * chs_pkg::SCAN_G;
  localparam int DIVW = 2 * chs_pkg::KEY_W;
  localparam logic [NW-1:0] NIL = NW'(NODE_POOL);

  chs_pkg::state_e  state_q, state_d;
  chs_pkg::func_e   func_q, func_d;
  chs_pkg::status_e res_q, res_d;
  logic [chs_pkg::CFG_W-1:0]     bcount_q;
  logic [chs_pkg::KEY_W-1:0]     key_q, key_d;
  logic [DIVW-1:0]               div_q, div_d;
  logic [chs_pkg::MOD_CNT_W-1:0] cnt_q, cnt_d;
  logic [DW-1:0]                 rem_q, rem_d;
  logic [BW-1:0]                 bkt_q, bkt_d;
  logic [NW-1:0]                 cur_q, cur_d, prev_q, prev_d, head_q, head_d;
  logic [IW-1:0]                 n_q, n_d;
  logic [GW-1:0]                 grp_q, grp_d;
  logic [LW-1:0]                 len_q, len_d, lo_q, lo_d, hi_q, hi_d;
  logic                          first_q, first_d;
  logic                          out_valid_q, out_valid_d;
  logic [chs_pkg::STATUS_W-1:0]  out_status_q, out_status_d;
  logic [chs_pkg::LEN_W-1:0]     out_min_q, out_min_d, out_max_q, out_max_d;

  logic [NODE_POOL-1:0]          free_q;
  logic [MAX_BUCKETS-1:0]        hvalid_q;
  logic [chs_pkg::KEY_W-1:0]     node_key_q [NODE_POOL];
  logic [NW-1:0]                 node_next_q [NODE_POOL];
  logic [NW-1:0]                 head_mem_q [MAX_BUCKETS];
  logic [chs_pkg::KEY_W-1:0]     key_rd_q;
  logic [NW-1:0]                 next_rd_q, head_rd_q;

  logic                          in_xfer, out_xfer, slot_free;
  logic [DW-1:0]                 beff, r;
  logic [DW:0]                   t;
  logic [PADW-1:0]               free_pad;
  logic [chs_pkg::SCAN_G-1:0]    grp_bits;
  logic [2:0]                    off;
  logic                          key_we, next_we, head_we, free_take, free_give, clear_all;
  logic [IW-1:0]                 next_waddr;
  logic [NW-1:0]                 next_wdata, head_wdata;

  assign in_stall_o = (state_q != chs_pkg::S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_q && !out_stall_i;
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign min_len_o   = out_min_q;
  assign max_len_o   = out_max_q;

  always_comb begin
    if (bcount_q == '0) begin
      beff = DW'(1);
    end else if (32'(bcount_q) > MAX_BUCKETS) begin
      beff = DW'(MAX_BUCKETS);
    end else begin
      beff = DW'(bcount_q);
    end
  end

  // Modulo unit: remainder digit steps, MSB first.
  always_comb begin
    r = rem_q;
    t = '0;
    for (int j = 0; j < chs_pkg::MOD_DIG; j++) begin
      t = {r, div_q[DIVW-1-j]};
      if (t >= {1'b0, beff}) begin
        t = t - {1'b0, beff};
      end
      r = t[DW-1:0];
    end
  end

  // Free-node scan, one group per cycle.
  assign free_pad = PADW'(free_q);
  assign grp_bits = free_pad[grp_q*chs_pkg::SCAN_G +: chs_pkg::SCAN_G];
  always_comb begin
    off = '0;
    for (int j = chs_pkg::SCAN_G - 1; j >= 0; j--) begin
      if (grp_bits[j]) begin
        off = 3'(j);
      end
    end
  end

  always_comb begin
    state_d = state_q;  func_d = func_q;   res_d = res_q;   key_d = key_q;
    div_d = div_q;      cnt_d = cnt_q;     rem_d = rem_q;   bkt_d = bkt_q;
    cur_d = cur_q;      prev_d = prev_q;   head_d = head_q; n_d = n_q;
    grp_d = grp_q;      len_d = len_q;     lo_d = lo_q;     hi_d = hi_q;
    first_d = first_q;
    out_valid_d = out_xfer ? 1'b0 : out_valid_q;
    out_status_d = out_status_q; out_min_d = out_min_q; out_max_d = out_max_q;
    key_we = 1'b0; next_we = 1'b0; head_we = 1'b0;
    free_take = 1'b0; free_give = 1'b0; clear_all = 1'b0;
    next_waddr = n_q; next_wdata = head_q; head_wdata = NW'(n_q);
    unique case (state_q)
      chs_pkg::S_IDLE: begin
        if (in_xfer) begin
          func_d = chs_pkg::func_e'(func_i);
          key_d  = key_i;
          div_d  = {{chs_pkg::KEY_W{key_i[chs_pkg::KEY_W-1]}}, key_i};
          cnt_d  = '0;
          rem_d  = '0;
          bkt_d  = '0;
          first_d = 1'b1;
          unique case (chs_pkg::func_e'(func_i))
            chs_pkg::FUNC_INSERT, chs_pkg::FUNC_REMOVE: state_d = chs_pkg::S_MOD;
            chs_pkg::FUNC_STATS:                        state_d = chs_pkg::S_SHRD;
            default:                                    state_d = chs_pkg::S_CLEAR;
          endcase
        end
      end
      chs_pkg::S_MOD: begin
        rem_d = r;
        div_d = div_q << chs_pkg::MOD_DIG;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == chs_pkg::MOD_CNT_W'(chs_pkg::MOD_CYC - 1)) begin
          bkt_d   = r[BW-1:0];
          state_d = chs_pkg::S_HRD;
        end
      end
      chs_pkg::S_HRD: state_d = chs_pkg::S_HGET;
      chs_pkg::S_HGET: begin
        cur_d   = hvalid_q[bkt_q] ? head_rd_q : NIL;
        head_d  = hvalid_q[bkt_q] ? head_rd_q : NIL;
        prev_d  = NIL;
        state_d = chs_pkg::S_NRD;
      end
      chs_pkg::S_NRD: begin
        if (cur_q == NIL) begin
          if (func_q == chs_pkg::FUNC_INSERT) begin
            grp_d   = '0;
            state_d = chs_pkg::S_SCAN;
          end else begin
            res_d   = chs_pkg::STAT_NOTFOUND;
            state_d = chs_pkg::S_DONE;
          end
        end else begin
          state_d = chs_pkg::S_NCHK;
        end
      end
      chs_pkg::S_NCHK: begin
        if (key_rd_q == key_q) begin
          if (func_q == chs_pkg::FUNC_INSERT) begin
            res_d = chs_pkg::STAT_DUP;
          end else begin
            res_d     = chs_pkg::STAT_REMOVED;
            free_give = 1'b1;
            if (prev_q == NIL) begin
              head_we    = 1'b1;
              head_wdata = next_rd_q;
            end else begin
              next_we    = 1'b1;
              next_waddr = prev_q[IW-1:0];
              next_wdata = next_rd_q;
            end
          end
          state_d = chs_pkg::S_DONE;
        end else begin
          prev_d  = cur_q;
          cur_d   = next_rd_q;
          state_d = chs_pkg::S_NRD;
        end
      end
      chs_pkg::S_SCAN: begin
        if (|grp_bits) begin
          n_d     = IW'({grp_q, off});
          state_d = chs_pkg::S_INS;
        end else if (grp_q == GW'(NG - 1)) begin
          res_d   = chs_pkg::STAT_FULL;
          state_d = chs_pkg::S_DONE;
        end else begin
          grp_d = grp_q + 1'b1;
        end
      end
      chs_pkg::S_INS: begin
        key_we    = 1'b1;
        next_we   = 1'b1;
        head_we   = 1'b1;
        free_take = 1'b1;
        res_d     = chs_pkg::STAT_INSERTED;
        state_d   = chs_pkg::S_DONE;
      end
      chs_pkg::S_SHRD: state_d = chs_pkg::S_SHGET;
      chs_pkg::S_SHGET: begin
        cur_d   = hvalid_q[bkt_q] ? head_rd_q : NIL;
        len_d   = '0;
        state_d = chs_pkg::S_SWALK;
      end
      chs_pkg::S_SWALK: begin
        if (cur_q == NIL) begin
          if (first_q || len_q < lo_q) lo_d = len_q;
          if (first_q || len_q > hi_q) hi_d = len_q;
          first_d = 1'b0;
          bkt_d   = bkt_q + 1'b1;
          if ((DW'(bkt_q) + DW'(1)) == beff) begin
            res_d   = chs_pkg::STAT_STATS;
            state_d = chs_pkg::S_DONE;
          end else begin
            state_d = chs_pkg::S_SHRD;
          end
        end else begin
          len_d   = len_q + 1'b1;
          state_d = chs_pkg::S_SNXT;
        end
      end
      chs_pkg::S_SNXT: begin
        cur_d   = next_rd_q;
        state_d = chs_pkg::S_SWALK;
      end
      chs_pkg::S_CLEAR: begin
        clear_all = 1'b1;
        res_d     = chs_pkg::STAT_CLEARED;
        state_d   = chs_pkg::S_DONE;
      end
      chs_pkg::S_DONE: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_q;
          if (res_q == chs_pkg::STAT_STATS) begin
            out_min_d = lo_q[chs_pkg::LEN_W-1:0];
            out_max_d = hi_q[chs_pkg::LEN_W-1:0];
          end else begin
            out_min_d = '0;
            out_max_d = '0;
          end
          state_d = chs_pkg::S_IDLE;
        end
      end
      default: state_d = chs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= chs_pkg::S_IDLE;
      bcount_q    <= chs_pkg::CFG_RESET;
      out_valid_q <= 1'b0;
      free_q      <= '1;
      hvalid_q    <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) bcount_q <= cfg_wdata_i;
      if (clear_all) begin
        free_q   <= '1;
        hvalid_q <= '0;
      end else begin
        if (free_take) free_q[n_q] <= 1'b0;
        if (free_give) free_q[cur_q[IW-1:0]] <= 1'b1;
        if (head_we) hvalid_q[bkt_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d;   res_q <= res_d;     key_q <= key_d;   div_q <= div_d;
    cnt_q <= cnt_d;     rem_q <= rem_d;     bkt_q <= bkt_d;   cur_q <= cur_d;
    prev_q <= prev_d;   head_q <= head_d;   n_q <= n_d;       grp_q <= grp_d;
    len_q <= len_d;     lo_q <= lo_d;       hi_q <= hi_d;     first_q <= first_d;
    out_status_q <= out_status_d;
    out_min_q    <= out_min_d;
    out_max_q    <= out_max_d;
  end

  always_ff @(posedge clk_i) begin
    if (key_we) node_key_q[n_q] <= key_q;
    key_rd_q <= node_key_q[cur_q[IW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (next_we) node_next_q[next_waddr] <= next_wdata;
    next_rd_q <= node_next_q[cur_q[IW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (head_we) head_mem_q[bkt_q] <= head_wdata;
    head_rd_q <= head_mem_q[bkt_q];
  end

  `CHS_ASSERT(a_busy_after_accept, in_xfer |=> (state_q != chs_pkg::S_IDLE))
  `CHS_ASSERT(a_ins_takes_free, (state_q == chs_pkg::S_INS) |-> free_q[n_q])
  `CHS_ASSERT(a_stats_order,
      (out_valid_o && status_o == chs_pkg::STAT_STATS) |-> (min_len_o <= max_len_o))
  `CHS_ASSERT(a_len_zero_else,
      (out_valid_o && status_o != chs_pkg::STAT_STATS) |-> (min_len_o == '0 && max_len_o == '0))
endmodule
`default_nettype wire

>>> sim/chs_checker.sv
// Transfer monitor, chained hash set predictor and result comparison.
`timescale 1ns / 100ps
module chs_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [chs_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [chs_pkg::FUNC_W-1:0]   func_i,
  input  logic [chs_pkg::KEY_W-1:0]    key_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [chs_pkg::STATUS_W-1:0] status_i,
  input  logic [chs_pkg::LEN_W-1:0]    min_len_i,
  input  logic [chs_pkg::LEN_W-1:0]    max_len_i,
  output int                           pending_o,
  output int                           errors_o
);
  localparam int NB = chs_pkg::MAX_BUCKETS_DEF;
  localparam int NP = chs_pkg::NODE_POOL_DEF;

  typedef struct packed {
    chs_pkg::status_e          status;
    logic [chs_pkg::LEN_W-1:0] min_len;
    logic [chs_pkg::LEN_W-1:0] max_len;
  } hash_result_t;

  hash_result_t              want_q[$];
  logic [chs_pkg::CFG_W-1:0] nbuckets;
  int                        head[NB];
  logic [chs_pkg::KEY_W-1:0] nkey[NP];
  int                        nnext[NP];
  bit                        nfree[NP];
  int                        errors;

  assign pending_o = want_q.size();
  assign errors_o  = errors;

  task automatic report(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    errors++;
  endtask

  task automatic empty_set();
    for (int i = 0; i < NB; i++) head[i] = NP;
    for (int i = 0; i < NP; i++) begin
      nfree[i] = 1'b1;
      nnext[i] = NP;
    end
  endtask

  function automatic int bucket_of(input logic [chs_pkg::KEY_W-1:0] k);
    logic [63:0] wide;
    int          n;
    n = (nbuckets == 0) ? 1 : (nbuckets > NB) ? NB : int'(nbuckets);
    wide = {{32{k[31]}}, k};
    return int'(wide % 64'(n));
  endfunction

  task automatic apply_command(input chs_pkg::func_e f,
                               input logic [chs_pkg::KEY_W-1:0] k,
                               output hash_result_t r);
    int b, cur, prev, n, len, lo, hi, nb;
    r = '{status: chs_pkg::STAT_CLEARED, min_len: '0, max_len: '0};
    case (f)
      chs_pkg::FUNC_INSERT: begin
        b = bucket_of(k);
        cur = head[b];
        r.status = chs_pkg::STAT_INSERTED;
        while (cur < NP) begin
          if (nkey[cur] == k) begin
            r.status = chs_pkg::STAT_DUP;
            break;
          end
          cur = nnext[cur];
        end
        if (r.status == chs_pkg::STAT_INSERTED) begin
          n = NP;
          for (int i = NP - 1; i >= 0; i--) if (nfree[i]) n = i;
          if (n == NP) r.status = chs_pkg::STAT_FULL;
          else begin
            nfree[n] = 1'b0;
            nkey[n] = k;
            nnext[n] = head[b];
            head[b] = n;
          end
        end
      end
      chs_pkg::FUNC_REMOVE: begin
        b = bucket_of(k);
        prev = NP;
        cur = head[b];
        r.status = chs_pkg::STAT_NOTFOUND;
        while (cur < NP) begin
          if (nkey[cur] == k) begin
            if (prev < NP) nnext[prev] = nnext[cur];
            else head[b] = nnext[cur];
            nfree[cur] = 1'b1;
            nnext[cur] = NP;
            r.status = chs_pkg::STAT_REMOVED;
            break;
          end
          prev = cur;
          cur = nnext[cur];
        end
      end
      chs_pkg::FUNC_STATS: begin
        nb = (nbuckets == 0) ? 1 : (nbuckets > NB) ? NB : int'(nbuckets);
        lo = 'h7fffffff;
        hi = 0;
        for (int i = 0; i < nb; i++) begin
          len = 0;
          cur = head[i];
          while (cur < NP) begin
            len++;
            cur = nnext[cur];
          end
          if (len < lo) lo = len;
          if (len > hi) hi = len;
        end
        r.status = chs_pkg::STAT_STATS;
        r.min_len = chs_pkg::LEN_W'(lo);
        r.max_len = chs_pkg::LEN_W'(hi);
      end
      default: empty_set();
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    hash_result_t r;
    if (!rst_ni) begin
      nbuckets = chs_pkg::CFG_RESET;
      empty_set();
      want_q.delete();
      errors = 0;
    end else begin
      if (cfg_we_i) nbuckets = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) begin
        apply_command(chs_pkg::func_e'(func_i), key_i, r);
        want_q.push_back(r);
      end
      if (out_valid_i && !out_stall_i) begin
        if (want_q.size() == 0) report("result transfer with nothing expected");
        else begin
          r = want_q.pop_front();
          if (status_i !== r.status)
            report($sformatf("status %0d, expected %0d", status_i, r.status));
          if (min_len_i !== r.min_len)
            report($sformatf("min_len %0d, expected %0d", min_len_i, r.min_len));
          if (max_len_i !== r.max_len)
            report($sformatf("max_len %0d, expected %0d", max_len_i, r.max_len));
        end
      end
    end
  end
endmodule

>>> sim/tb.sv
// Top of the chained hash set testbench: clock, reset, command stimulus and verdict.
`timescale 1ns / 100ps
module tb;
  localparam int STALL_LIMIT = 4000;
  localparam int INT_MIN_K   = 32'h8000_0000;
  localparam int INT_MAX_K   = 32'h7fff_ffff;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic [chs_pkg::CFG_W-1:0]    cfg_wdata_i = '0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic [chs_pkg::FUNC_W-1:0]   func_i = chs_pkg::FUNC_STATS;
  logic [chs_pkg::KEY_W-1:0]    key_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [chs_pkg::STATUS_W-1:0] status_o;
  logic [chs_pkg::LEN_W-1:0]    min_len_o;
  logic [chs_pkg::LEN_W-1:0]    max_len_o;
  int                           pending, errors;
  int                           send_idle_pct = 0, recv_stall_pct = 0;
  int                           sent = 0, cfg_writes = 0, quiet = 0, hold_left = 0;
  bit                           hold_done = 1'b0;
  logic [chs_pkg::KEY_W-1:0]    key_base;

  always #6 clk_i = ~clk_i;

  chained_hash_set u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o, .func_i, .key_i,
    .out_valid_o, .out_stall_i, .status_o, .min_len_o, .max_len_o
  );

  chs_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_i(in_stall_o),
    .func_i, .key_i, .out_valid_i(out_valid_o), .out_stall_i, .status_i(status_o),
    .min_len_i(min_len_o), .max_len_i(max_len_o), .pending_o(pending), .errors_o(errors)
  );

  // receiver: random stall, plus one long hold-off to back the block up
  always @(posedge clk_i) begin
    if (!hold_done && sent >= 100) begin
      hold_done <= 1'b1;
      hold_left <= 300;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("timeout after %0d idle cycles", quiet);
      $display("tb failed");
      $finish;
    end
  end

  task automatic send(input chs_pkg::func_e f, input logic [chs_pkg::KEY_W-1:0] k);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    key_i <= k;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
    if (sent < 540) begin
      send_idle_pct = 8;
      recv_stall_pct = 59;
    end else if (sent < 1080) begin
      send_idle_pct = 59;
      recv_stall_pct = 8;
    end else begin
      send_idle_pct = 0;
      recv_stall_pct = 0;
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_bucket_count(input logic [chs_pkg::CFG_W-1:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_writes++;
  endtask

  function automatic logic [chs_pkg::KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 65) return key_base + $urandom_range(0, 399);
    if (r < 80) return -$urandom_range(1, 300);
    return $urandom;
  endfunction

  task automatic random_phase(input int n, input int ins_pct);
    int r;
    chs_pkg::func_e f;
    key_base = $urandom;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      f = (r < ins_pct) ? chs_pkg::FUNC_INSERT :
          (r < ins_pct + 30) ? chs_pkg::FUNC_REMOVE :
          (r < 99) ? chs_pkg::FUNC_STATS : chs_pkg::FUNC_CLEAR;
      send(f, pick_key());
    end
  endtask

  initial begin
    logic [chs_pkg::KEY_W-1:0] fill_keys[$];
    send_idle_pct = 8;
    recv_stall_pct = 59;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, duplicates, misses, stats, clear
    send(chs_pkg::FUNC_INSERT, '0);
    send(chs_pkg::FUNC_INSERT, '0);
    send(chs_pkg::FUNC_INSERT, INT_MAX_K);
    send(chs_pkg::FUNC_INSERT, INT_MIN_K);
    send(chs_pkg::FUNC_INSERT, '1);
    send(chs_pkg::FUNC_STATS, '1);
    send(chs_pkg::FUNC_REMOVE, '1);
    send(chs_pkg::FUNC_REMOVE, '1);
    send(chs_pkg::FUNC_REMOVE, INT_MIN_K);
    send(chs_pkg::FUNC_STATS, '0);
    send(chs_pkg::FUNC_CLEAR, 32'h5a5a_a5a5);
    send(chs_pkg::FUNC_STATS, '0);
    send(chs_pkg::FUNC_REMOVE, 32'd5);
    write_bucket_count('0);
    send(chs_pkg::FUNC_INSERT, 32'd5);
    send(chs_pkg::FUNC_INSERT, -32'sd5);
    send(chs_pkg::FUNC_STATS, '0);
    write_bucket_count(7'd127);
    send(chs_pkg::FUNC_STATS, '0);
    send(chs_pkg::FUNC_INSERT, 32'd69);
    send(chs_pkg::FUNC_STATS, '0);

    // fill the node pool, overflow it, then free and reuse nodes
    write_bucket_count(7'd3);
    send(chs_pkg::FUNC_CLEAR, '0);
    key_base = $urandom;
    for (int i = 0; i < 258; i++) begin
      fill_keys.push_back(key_base + i * 7);
      send(chs_pkg::FUNC_INSERT, fill_keys[i]);
    end
    send(chs_pkg::FUNC_INSERT, fill_keys[0]);
    send(chs_pkg::FUNC_STATS, '0);
    for (int i = 0; i < 6; i++)
      send(chs_pkg::FUNC_REMOVE, fill_keys[$urandom_range(0, 257)]);
    drain();
    for (int i = 0; i < 6; i++)
      send(chs_pkg::FUNC_INSERT, fill_keys[$urandom_range(0, 257)]);
    send(chs_pkg::FUNC_STATS, '0);

    // random phases over several bucket counts; chains kept across count changes
    write_bucket_count(7'd1);
    random_phase(220, 60);
    write_bucket_count('0);
    random_phase(220, 45);
    write_bucket_count(7'd127);
    random_phase(220, 60);
    write_bucket_count(7'd64);
    random_phase(220, 45);
    write_bucket_count(7'($urandom_range(2, 63)));
    random_phase(220, 55);
    write_bucket_count(7'd7);
    random_phase(200, 50);

    drain();
    repeat (100) @(posedge clk_i);
    $display("covered %0d commands over %0d bucket count settings,", sent, cfg_writes);
    $display("including a full node pool and a long result hold-off");
    if (errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end
endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/chs_pkg.sv
rtl/core/chained_hash_set.sv
sim/chs_checker.sv
sim/tb.sv
